>>> sv/hcc_pkg.sv
// ----------------------------------------------------------------------------
// hcc_pkg: shared types and constants of the headway cruise controller
// Transaction types, state codes, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package hcc_pkg;

    // Width of the serial multiply accumulator and of the Q8.8 gains.
    localparam int ACC_W  = 64;
    localparam int GAIN_W = 16;
    localparam int CNT_W  = 4;
    localparam int GAP_W  = 33;
    localparam int GERR_W = 42;

    // Register reset values.
    localparam logic        [15:0] HEADWAY_RST   = 16'd384;
    localparam logic        [30:0] MIN_GAP_RST   = 31'd327680;
    localparam logic signed [15:0] GAP_GAIN_RST  = 16'sd51;
    localparam logic signed [15:0] RELV_GAIN_RST = 16'sd128;
    localparam logic signed [15:0] CLS_GAIN_RST  = 16'sd0;
    localparam logic signed [31:0] ACC_MIN_RST   = -32'sd393216;
    localparam logic signed [31:0] ACC_MAX_RST   = 32'sd131072;
    localparam logic signed [31:0] POS_MAX       = 32'sh7FFFFFFF;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_HEADWAY   = 3'd0,
        CFG_MIN_GAP   = 3'd1,
        CFG_GAP_GAIN  = 3'd2,
        CFG_RELV_GAIN = 3'd3,
        CFG_CLS_GAIN  = 3'd4,
        CFG_ACC_MIN   = 3'd5,
        CFG_ACC_MAX   = 3'd6
    } t_cfg_idx;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_HDW,
        S_GERR,
        S_MUL,
        S_WAIT,
        S_FIN
    } t_state;

    // Which gain term the shared multiplier is working on.
    typedef enum logic [1:0] {
        PH_GAP,
        PH_RVEL,
        PH_CLOSE
    } t_phase;

    typedef struct packed {
        logic signed [31:0] ego_position;
        logic signed [31:0] ego_velocity;
        logic signed [31:0] lead_position;
        logic signed [31:0] lead_velocity;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] accel_command;
        logic signed [31:0] gap_error;
        logic signed [31:0] relative_velocity;
        logic signed [31:0] least_gap_seen;
        logic signed [31:0] least_ttc_seen;
        logic signed [31:0] hardest_decel_seen;
        logic               collision_seen;
        logic               unsafe_gap_seen;
    } t_out_item;

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(POS_MAX);
        lo = -hi - ACC_W'(1);
        if (v > hi) begin
            return POS_MAX;
        end else if (v < lo) begin
            return -POS_MAX - 32'sd1;
        end
        return v[31:0];
    endfunction

endpackage

`default_nettype wire

>>> sv/hcc_div.sv
// ----------------------------------------------------------------------------
// hcc_div: bit-serial restoring divider
// Unsigned division of a DW-bit dividend by a 33-bit divisor, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hcc_div #(
    parameter int DW = 49
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [32:0]   i_divisor,
    output logic               o_done,
    output logic [DW-1:0]      o_quotient
);
    localparam int CW = $clog2(DW + 1);

    logic [CW-1:0] r_cnt;
    logic [33:0]   r_rem;
    logic [DW-1:0] r_num;
    logic [32:0]   r_div;
    logic [33:0]   trial;
    logic          fits;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    assign trial = {r_rem[32:0], r_num[DW-1]};
    assign fits  = trial >= {1'b0, r_div};

    // Counter of remaining quotient bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(DW);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CW'(1);
        end
    end

    // Remainder and dividend/quotient shift register.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_num <= i_dividend;
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= fits ? (trial - {1'b0, r_div}) : trial;
            r_num <= {r_num[DW-2:0], fits};
        end
    end

    assign o_done     = (r_cnt == '0) && !i_start;
    assign o_quotient = r_num;

endmodule

`default_nettype wire

>>> sv/headway_cruise_controller.sv
// ----------------------------------------------------------------------------
// headway_cruise_controller: constant time headway cruise control
// Computes the acceleration command and running safety monitors per sample.
// ----------------------------------------------------------------------------
// Usage: one input transaction carries ego and lead position and velocity in
// signed fixed point. A shared bit-serial multiplier forms the headway product
// and then the three gain terms, while a bit-serial divider works out the
// time to collision alongside. Items do not overlap: after its four multiply
// passes and the division, each item leaves the final step before the next.
// o_in_stall is high while an item is in work. The result sits in an output
// register, so a new item is accepted while the previous result waits; if the
// receiver still stalls when the next result is ready, the block holds it in
// its final step until the register frees. Reset restores the register
// defaults and clears all monitors.
// Configuration writes are taken on any cycle with i_cfg_we high and are
// expected only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module headway_cruise_controller #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire hcc_pkg::t_in_item i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output hcc_pkg::t_out_item     o_out_data,
    input  wire logic              i_cfg_we,
    input  wire logic [2:0]        i_cfg_idx,
    input  wire logic [31:0]       i_cfg_data
);
    import hcc_pkg::*;

    localparam int DW = GAP_W + FRAC_BITS;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(GAIN_W - 1);
    localparam logic signed [31:0] TTC_NONE = -(32'sd1 <<< FRAC_BITS);

    // Configuration registers.
    logic        [15:0] r_headway;
    logic        [30:0] r_min_gap;
    logic signed [15:0] r_gap_gain;
    logic signed [15:0] r_relv_gain;
    logic signed [15:0] r_cls_gain;
    logic signed [31:0] r_acc_min;
    logic signed [31:0] r_acc_max;

    // Sequencer and datapath registers.
    t_state r_state, n_state;
    t_phase r_phase;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  r_mcand;
    logic        [GAIN_W-1:0] r_mplier;
    logic        [CNT_W-1:0]  r_cnt;
    logic                     r_msigned;
    logic                     r_mneg;
    logic signed [GAP_W-1:0]  r_gap;
    logic signed [GAP_W-1:0]  r_rvel;
    logic signed [GERR_W-1:0] r_gerr;

    // Monitors.
    logic signed [31:0] r_least_gap;
    logic signed [31:0] r_least_ttc;
    logic               r_ttc_valid;
    logic signed [31:0] r_hard;
    logic               r_coll;
    logic               r_unsafe;

    // Output register.
    logic      r_out_valid;
    t_out_item r_out;

    logic          div_done;
    logic [DW-1:0] div_q;
    logic          in_acc;
    logic          can_load;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign can_load = !r_out_valid || !i_out_stall;

    // Time to collision divider.
    hcc_div #(.DW(DW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_acc),
        .i_dividend ({GAP_W'($signed(i_in_data.lead_position))
                      - GAP_W'($signed(i_in_data.ego_position)),
                      FRAC_BITS'(0)}),
        .i_divisor  (GAP_W'($signed(i_in_data.ego_velocity))
                     - GAP_W'($signed(i_in_data.lead_velocity))),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_headway   <= HEADWAY_RST;
            r_min_gap   <= MIN_GAP_RST;
            r_gap_gain  <= GAP_GAIN_RST;
            r_relv_gain <= RELV_GAIN_RST;
            r_cls_gain  <= CLS_GAIN_RST;
            r_acc_min   <= ACC_MIN_RST;
            r_acc_max   <= ACC_MAX_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HEADWAY:   r_headway   <= i_cfg_data[15:0];
                CFG_MIN_GAP:   r_min_gap   <= i_cfg_data[30:0];
                CFG_GAP_GAIN:  r_gap_gain  <= i_cfg_data[15:0];
                CFG_RELV_GAIN: r_relv_gain <= i_cfg_data[15:0];
                CFG_CLS_GAIN:  r_cls_gain  <= i_cfg_data[15:0];
                CFG_ACC_MIN:   r_acc_min   <= i_cfg_data;
                CFG_ACC_MAX:   r_acc_max   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // One shift-add step of the serial multiplier.
    logic signed [ACC_W-1:0] addend;
    logic                    sub;
    logic signed [ACC_W-1:0] acc_step;
    assign addend   = r_mplier[0] ? r_mcand : '0;
    assign sub      = ((r_cnt == LAST) && r_msigned) ^ r_mneg;
    assign acc_step = sub ? (r_acc - addend) : (r_acc + addend);

    // Gap error from the finished headway product.
    logic signed [ACC_W-1:0] desired;
    logic signed [ACC_W-1:0] gerr_full;
    assign desired   = ACC_W'(signed'({1'b0, r_min_gap})) + (r_acc >>> 8);
    assign gerr_full = ACC_W'(r_gap) - desired;

    // Closing speed and its positive part.
    logic signed [GAP_W-1:0] closing;
    logic signed [GAP_W-1:0] closing_pos;
    assign closing     = -r_rvel;
    assign closing_pos = (closing > 0) ? closing : '0;

    // Final command, override and monitor updates.
    logic signed [ACC_W-1:0] raw;
    logic signed [31:0]      cmd;
    logic                    ttc_case;
    logic signed [GAP_W+2:0] gap_x2;
    logic signed [GAP_W+2:0] cls_x3;
    logic signed [31:0]      ttc_q;
    logic signed [31:0]      gap_sat;
    logic signed [31:0]      n_least_gap;
    logic signed [31:0]      n_least_ttc;
    logic                    n_ttc_valid;
    logic signed [31:0]      n_hard;
    logic                    n_coll;
    logic                    n_unsafe;

    always_comb begin
        raw = r_acc >>> 8;
        if (raw < ACC_W'(r_acc_min)) begin
            cmd = r_acc_min;
        end else if (raw > ACC_W'(r_acc_max)) begin
            cmd = r_acc_max;
        end else begin
            cmd = raw[31:0];
        end
        ttc_case = (closing > 0) && (r_gap > 0);
        gap_x2   = (GAP_W+3)'(r_gap) <<< 1;
        cls_x3   = ((GAP_W+3)'(closing) <<< 1) + (GAP_W+3)'(closing);
        if (ttc_case && (gap_x2 < cls_x3)) begin
            cmd = r_acc_min;
        end
        ttc_q = (|div_q[DW-1:31]) ? POS_MAX : signed'({1'b0, div_q[30:0]});
        n_least_ttc = r_least_ttc;
        n_ttc_valid = r_ttc_valid;
        if (ttc_case) begin
            if (!r_ttc_valid || (ttc_q < r_least_ttc)) begin
                n_least_ttc = ttc_q;
            end
            n_ttc_valid = 1'b1;
        end
        n_hard      = (cmd < r_hard) ? cmd : r_hard;
        gap_sat     = sat32(ACC_W'(r_gap));
        n_least_gap = (gap_sat < r_least_gap) ? gap_sat : r_least_gap;
        n_coll      = r_coll || (r_gap <= 0);
        n_unsafe    = r_unsafe || (r_gap < GAP_W'(signed'({1'b0, r_min_gap})));
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (in_acc) n_state = S_HDW;
            S_HDW:  if (r_cnt == LAST) n_state = S_GERR;
            S_GERR: n_state = S_MUL;
            S_MUL:  if ((r_cnt == LAST) && (r_phase == PH_CLOSE)) n_state = S_WAIT;
            S_WAIT: if (div_done) n_state = S_FIN;
            S_FIN:  if (can_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    // Multiplier datapath and captured operands.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_gap     <= GAP_W'($signed(i_in_data.lead_position))
                                 - GAP_W'($signed(i_in_data.ego_position));
                    r_rvel    <= GAP_W'($signed(i_in_data.lead_velocity))
                                 - GAP_W'($signed(i_in_data.ego_velocity));
                    r_acc     <= '0;
                    r_mcand   <= ACC_W'($signed(i_in_data.ego_velocity));
                    r_mplier  <= r_headway;
                    r_cnt     <= '0;
                    r_msigned <= 1'b0;
                    r_mneg    <= 1'b0;
                end
            end
            S_HDW: begin
                r_acc    <= acc_step;
                r_mcand  <= r_mcand <<< 1;
                r_mplier <= r_mplier >> 1;
                r_cnt    <= r_cnt + CNT_W'(1);
            end
            S_GERR: begin
                r_gerr    <= gerr_full[GERR_W-1:0];
                r_acc     <= '0;
                r_mcand   <= gerr_full;
                r_mplier  <= r_gap_gain;
                r_cnt     <= '0;
                r_msigned <= 1'b1;
                r_mneg    <= 1'b0;
                r_phase   <= PH_GAP;
            end
            S_MUL: begin
                r_acc <= acc_step;
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == LAST) begin
                    case (r_phase)
                        PH_GAP: begin
                            r_mcand  <= ACC_W'(r_rvel);
                            r_mplier <= r_relv_gain;
                            r_phase  <= PH_RVEL;
                        end
                        PH_RVEL: begin
                            r_mcand  <= ACC_W'(closing_pos);
                            r_mplier <= r_cls_gain;
                            r_mneg   <= 1'b1;
                            r_phase  <= PH_CLOSE;
                        end
                        default: ;
                    endcase
                end else begin
                    r_mcand  <= r_mcand <<< 1;
                    r_mplier <= r_mplier >> 1;
                end
            end
            default: ;
        endcase
    end

    // Monitors advance as each result is formed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_least_gap <= POS_MAX;
            r_least_ttc <= POS_MAX;
            r_ttc_valid <= 1'b0;
            r_hard      <= '0;
            r_coll      <= 1'b0;
            r_unsafe    <= 1'b0;
        end else if ((r_state == S_FIN) && can_load) begin
            r_least_gap <= n_least_gap;
            r_least_ttc <= n_least_ttc;
            r_ttc_valid <= n_ttc_valid;
            r_hard      <= n_hard;
            r_coll      <= n_coll;
            r_unsafe    <= n_unsafe;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_FIN) && can_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_FIN) && can_load) begin
            r_out.accel_command      <= cmd;
            r_out.gap_error          <= sat32(ACC_W'(r_gerr));
            r_out.relative_velocity  <= sat32(ACC_W'(r_rvel));
            r_out.least_gap_seen     <= n_least_gap;
            r_out.least_ttc_seen     <= n_ttc_valid ? n_least_ttc : TTC_NONE;
            r_out.hardest_decel_seen <= n_hard;
            r_out.collision_seen     <= n_coll;
            r_out.unsafe_gap_seen    <= n_unsafe;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTH
    // The hardest deceleration monitor never rises above zero.
    a_hard_nonpos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hard[31] || (r_hard == '0)))
        else $error("hardest deceleration became positive");

    // A recorded time to collision is never negative.
    a_ttc_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ttc_valid |-> !r_least_ttc[31])
        else $error("negative time to collision recorded");

    // The result is formed only after the divider has finished.
    a_div_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> div_done)
        else $error("result formed before division finished");

    // An accepted transaction starts the headway multiply.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_HDW))
        else $error("accepted transaction did not start");
`endif

endmodule

`default_nettype wire
